// ----- hdl/wdtp_pkg.sv -----
package wdtp_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned OffsetWidth = 8;
  localparam int unsigned PeriodWidth = 15;

  localparam logic [DataWidth-1:0] ConReset = 32'h0000_8001;
  localparam logic [DataWidth-1:0] DatReset = 32'h0000_8000;
  localparam logic [DataWidth-1:0] CntReset = 32'h0000_8000;
  localparam logic [DataWidth-1:0] ClrReset = 32'h0000_0000;

  localparam int unsigned BitEnable      = 5;
  localparam int unsigned BitResetEnable = 0;

  localparam logic [OffsetWidth-1:0] OffControl = 8'd0;
  localparam logic [OffsetWidth-1:0] OffData    = 8'd4;
  localparam logic [OffsetWidth-1:0] OffCount   = 8'd8;
  localparam logic [OffsetWidth-1:0] OffClear   = 8'd12;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic [OffsetWidth-1:0] byte_offset;
    logic [DataWidth-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq_level;
    logic                 reset_pulse;
    logic                 running;
  } result_t;

endpackage

// ----- hdl/wdtp_in_if.sv -----
interface wdtp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  byte_offset;
  logic [31:0] write_data;

  modport source (output valid, output operation, output byte_offset, output write_data,
                  input ready);
  modport sink (input valid, input operation, input byte_offset, input write_data,
                output ready);
endinterface

// ----- hdl/wdtp_out_if.sv -----
interface wdtp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;
  logic        reset_pulse;
  logic        running;

  modport source (output valid, output read_data, output irq_level, output reset_pulse,
                  output running, input ready);
  modport sink (input valid, input read_data, input irq_level, input reset_pulse,
                input running, output ready);
endinterface

// ----- hdl/watchdog_timer_with_prescaler.sv -----
// Watchdog timer with prescaler and divider behind a four-register bus map.
// Input channel item_i carries one word per step: a bus read, a bus write or
// one peripheral clock tick (operation), the register byte offset and the
// write data. Output channel result_o returns one word per input word: the
// read data, the interrupt level, the expiry reset pulse and the running flag.
// Both channels use valid/ready; a word moves when both are high.
// A result passes from the input register to the result register and is
// then offered on result_o. Throughput: one word per cycle while the
// receiver keeps ready high, with the register update and tick decrement
// done as each word leaves the input register.
// A control write with enable set arms a timeout of count x prescaler x
// divider ticks and reloads the registers; expiry raises the interrupt,
// which stays high until reset, and gives a one-tick reset pulse.
// Reset restores the register reset values, disarms the timer and clears
// the interrupt; no word is in flight afterwards.
// When the receiver stalls, results hold in the output register and the
// input register; input ready drops only once both are full.
module watchdog_timer_with_prescaler (
  input  logic      clk_i,
  input  logic      rst_ni,
  wdtp_in_if.sink   item_i,
  wdtp_out_if.source result_o
);
  import wdtp_pkg::*;

  item_t   item;
  logic    core_valid;
  logic    core_ready;
  result_t core_result;

  assign item.operation   = item_i.operation;
  assign item.byte_offset = item_i.byte_offset;
  assign item.write_data  = item_i.write_data;

  wdtp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_ready_o   (item_i.ready),
    .in_item_i    (item),
    .out_ready_i  (core_ready),
    .out_valid_o  (core_valid),
    .out_result_o (core_result)
  );

  wdtp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (core_valid),
    .in_ready_o  (core_ready),
    .in_result_i (core_result),
    .result_o    (result_o)
  );

endmodule

// ----- hdl/wdtp_core.sv -----
module wdtp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wdtp_pkg::item_t  in_item_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output wdtp_pkg::result_t out_result_o
);
  import wdtp_pkg::*;

  logic                   s1_valid_q;
  item_t                  s1_item_q;
  logic                   advance;

  logic [DataWidth-1:0]   control_q, control_d;
  logic [DataWidth-1:0]   data_q, data_d;
  logic [DataWidth-1:0]   count_q, count_d;
  logic [DataWidth-1:0]   clear_q, clear_d;
  logic                   armed_q, armed_d;
  logic [PeriodWidth-1:0] tick_period_q, tick_period_d;
  logic [PeriodWidth-1:0] period_left_q, period_left_d;
  logic [DataWidth-1:0]   units_left_q, units_left_d;
  logic                   irq_q, irq_d;

  logic [7:0]             pre;
  logic [1:0]             sel;
  logic [PeriodWidth-1:0] period;
  logic [PeriodWidth-1:0] period_dec;
  logic [DataWidth-1:0]   units_dec;
  logic                   en_bit;
  logic                   re_bit;
  logic                   pulse;
  logic [DataWidth-1:0]   rdata;

  assign advance     = s1_valid_q && out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  assign pre        = s1_item_q.write_data[15:8];
  assign sel        = s1_item_q.write_data[4:3];
  assign period     = PeriodWidth'({(pre == 8'd0) ? 8'd1 : pre, 4'b0000}) << sel;
  assign en_bit     = s1_item_q.write_data[BitEnable];
  assign re_bit     = s1_item_q.write_data[BitResetEnable];
  assign period_dec = period_left_q - PeriodWidth'(1);
  assign units_dec  = units_left_q - DataWidth'(1);

  always_comb begin
    control_d     = control_q;
    data_d        = data_q;
    count_d       = count_q;
    clear_d       = clear_q;
    armed_d       = armed_q;
    tick_period_d = tick_period_q;
    period_left_d = period_left_q;
    units_left_d  = units_left_q;
    irq_d         = irq_q;
    pulse         = 1'b0;
    rdata         = '0;
    unique case (s1_item_q.operation)
      OP_READ: begin
        unique case (s1_item_q.byte_offset)
          OffControl: rdata = control_q;
          OffData:    rdata = data_q;
          OffCount:   rdata = count_q;
          OffClear:   rdata = clear_q;
          default:    rdata = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (s1_item_q.byte_offset)
          OffControl: begin
            control_d = s1_item_q.write_data;
            if (en_bit) begin
              control_d     = ConReset;
              data_d        = DatReset;
              count_d       = CntReset;
              clear_d       = ClrReset;
              tick_period_d = period;
              period_left_d = period;
              units_left_d  = count_q;
              armed_d       = 1'b1;
            end else if (!re_bit) begin
              armed_d = 1'b0;
            end
          end
          OffData:  data_d  = s1_item_q.write_data;
          OffCount: count_d = s1_item_q.write_data;
          OffClear: clear_d = s1_item_q.write_data;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (armed_q) begin
          if (units_left_q == '0) begin
            pulse = 1'b1;
          end else if (period_dec != '0) begin
            period_left_d = period_dec;
          end else begin
            units_left_d  = units_dec;
            period_left_d = tick_period_q;
            pulse         = (units_dec == '0);
          end
          if (pulse) begin
            armed_d = 1'b0;
            irq_d   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q     <= ConReset;
      data_q        <= DatReset;
      count_q       <= CntReset;
      clear_q       <= ClrReset;
      armed_q       <= 1'b0;
      tick_period_q <= '0;
      period_left_q <= '0;
      units_left_q  <= '0;
      irq_q         <= 1'b0;
    end else if (advance) begin
      control_q     <= control_d;
      data_q        <= data_d;
      count_q       <= count_d;
      clear_q       <= clear_d;
      armed_q       <= armed_d;
      tick_period_q <= tick_period_d;
      period_left_q <= period_left_d;
      units_left_q  <= units_left_d;
      irq_q         <= irq_d;
    end
  end

  assign out_result_o.read_data   = rdata;
  assign out_result_o.irq_level   = irq_d;
  assign out_result_o.reset_pulse = pulse;
  assign out_result_o.running     = armed_d;

  a_irq_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q |=> irq_q) else $error("irq dropped");

  a_pulse_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && pulse) |=> (irq_q && !armed_q)) else $error("expiry left timer armed");

  a_period_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q && units_left_q != '0) |-> (period_left_q != '0))
    else $error("armed with empty period");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_ready_i) |=> s1_valid_q) else $error("stalled word lost");

endmodule

// ----- hdl/wdtp_out_reg.sv -----
module wdtp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wdtp_pkg::result_t in_result_i,
  wdtp_out_if.source        result_o
);
  import wdtp_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign in_ready_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      result_q <= in_result_i;
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.read_data   = result_q.read_data;
  assign result_o.irq_level   = result_q.irq_level;
  assign result_o.reset_pulse = result_q.reset_pulse;
  assign result_o.running     = result_q.running;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wdtp_pkg::*;

  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned WordsPerPhase = 310;
  localparam int unsigned SequenceGuard = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wdtp_in_if in_if ();
  wdtp_out_if out_if ();

  watchdog_timer_with_prescaler dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog state as seen through the bus
  logic [31:0] wd_ctrl = ConReset;
  logic [31:0] wd_data = DatReset;
  logic [31:0] wd_count = CntReset;
  logic [31:0] wd_clear = ClrReset;
  logic wd_armed = 1'b0;
  logic [PeriodWidth-1:0] wd_period = '0;
  logic [PeriodWidth-1:0] wd_period_left = '0;
  logic [31:0] wd_units_left = '0;
  logic wd_irq = 1'b0;

  result_t expected_results[$];
  result_t want;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  function automatic void reload_registers();
    wd_ctrl = ConReset;
    wd_data = DatReset;
    wd_count = CntReset;
    wd_clear = ClrReset;
  endfunction

  function automatic logic tick_watchdog();
    if (!wd_armed) return 1'b0;
    if (wd_units_left != 0) begin
      wd_period_left = wd_period_left - 1'b1;
      if (wd_period_left != 0) return 1'b0;
      wd_units_left = wd_units_left - 1;
      wd_period_left = wd_period;
      if (wd_units_left != 0) return 1'b0;
    end
    wd_armed = 1'b0;
    wd_irq = 1'b1;
    return 1'b1;
  endfunction

  function automatic void write_control(logic [31:0] value);
    int unsigned pre;
    int unsigned div;
    logic [31:0] count_before;
    pre = 32'(value[15:8]);
    if (pre == 0) pre = 1;
    div = 16 << value[4:3];
    count_before = wd_count;
    wd_ctrl = value;
    if (!value[BitEnable] && !value[BitResetEnable]) begin
      wd_armed = 1'b0;
    end else if (value[BitEnable]) begin
      reload_registers();
      wd_period = PeriodWidth'(pre * div);
      wd_period_left = wd_period;
      wd_units_left = count_before;
      wd_armed = 1'b1;
    end
  endfunction

  function automatic result_t predict_watchdog(logic [1:0] op, logic [7:0] off,
                                               logic [31:0] wdata);
    result_t r;
    r = '0;
    case (op)
      OP_READ: begin
        case (off)
          OffControl: r.read_data = wd_ctrl;
          OffData:    r.read_data = wd_data;
          OffCount:   r.read_data = wd_count;
          OffClear:   r.read_data = wd_clear;
          default:    r.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (off)
          OffControl: write_control(wdata);
          OffData:    wd_data = wdata;
          OffCount:   wd_count = wdata;
          OffClear:   wd_clear = wdata;
          default: ;
        endcase
      end
      OP_TICK: r.reset_pulse = tick_watchdog();
      default: ;
    endcase
    r.irq_level = wd_irq;
    r.running = wd_armed;
    return r;
  endfunction

  task automatic send_word(logic [1:0] op, logic [7:0] off, logic [31:0] wdata);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.byte_offset <= off;
    in_if.write_data <= wdata;
    do @(posedge clk_i); while (!in_if.ready);
    expected_results.push_back(predict_watchdog(op, off, wdata));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.read_data !== want.read_data) begin
          $error("read_data expected %h got %h", want.read_data, out_if.read_data);
          mismatches++;
        end
        if (out_if.irq_level !== want.irq_level) begin
          $error("irq_level expected %b got %b", want.irq_level, out_if.irq_level);
          mismatches++;
        end
        if (out_if.reset_pulse !== want.reset_pulse) begin
          $error("reset_pulse expected %b got %b", want.reset_pulse, out_if.reset_pulse);
          mismatches++;
        end
        if (out_if.running !== want.running) begin
          $error("running expected %b got %b", want.running, out_if.running);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_register_map();
    send_word(OP_READ, OffControl, '0);
    send_word(OP_READ, OffData, '0);
    send_word(OP_READ, OffCount, '0);
    send_word(OP_READ, OffClear, '0);
    send_word(OP_WRITE, OffData, 32'hffff_ffff);
    send_word(OP_READ, OffData, '0);
    send_word(OP_WRITE, OffClear, 32'hffff_ffff);
    send_word(OP_READ, OffClear, 32'hffff_ffff);
    send_word(OP_WRITE, 8'hff, 32'hffff_ffff);
    send_word(OP_READ, 8'hff, '0);
    send_word(OP_READ, 8'd5, '0);
    send_word(OpNone, OffControl, 32'hffff_ffff);
    send_word(OP_WRITE, OffData, '0);
  endtask

  task automatic test_countdown();
    logic [31:0] ctrl;
    // zero count expires on the first tick
    send_word(OP_WRITE, OffCount, '0);
    ctrl = '0;
    ctrl[BitEnable] = 1'b1;
    send_word(OP_WRITE, OffControl, ctrl);
    send_word(OP_TICK, '0, '0);
    send_word(OP_READ, OffControl, '0);
    // re-arm restarts from the count held before the write
    send_word(OP_WRITE, OffCount, 32'd1);
    send_word(OP_WRITE, OffControl, ctrl);
    send_word(OP_TICK, '0, '0);
    send_word(OP_WRITE, OffControl, ctrl | 32'hff18);
    send_word(OP_READ, OffCount, '0);
    ctrl = '0;
    ctrl[BitResetEnable] = 1'b1;
    send_word(OP_WRITE, OffControl, ctrl);
    send_word(OP_TICK, '0, '0);
    send_word(OP_WRITE, OffControl, '0);
    send_word(OP_TICK, '0, '0);
  endtask

  task automatic noise_word(bit allow_control);
    logic [1:0] op;
    logic [7:0] off;
    op = 2'($urandom_range(3));
    off = $urandom_range(1) ? 8'($urandom_range(3) * 4) : 8'($urandom_range(255));
    if (!allow_control && op == OP_WRITE && (off == OffControl || off == OffCount))
      op = OP_READ;
    send_word(op, off, $urandom);
  endtask

  task automatic run_timeout_sequence();
    logic [31:0] ctrl;
    int unsigned guard;
    send_word(OP_WRITE, OffCount, $urandom_range(2));
    ctrl = $urandom;
    ctrl[15:8] = ($urandom_range(7) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(1));
    ctrl[4:3] = 2'($urandom_range(3));
    ctrl[BitEnable] = 1'b1;
    if ($urandom_range(3) == 0) send_word(OP_READ, OffCount, $urandom);
    send_word(OP_WRITE, OffControl, ctrl);
    guard = 0;
    while (wd_armed && guard < SequenceGuard) begin
      case ($urandom_range(39))
        0, 1, 2: noise_word(1'b0);
        3: begin
          ctrl[BitEnable] = 1'b0;
          ctrl[BitResetEnable] = 1'($urandom_range(1));
          send_word(OP_WRITE, OffControl, ctrl);
        end
        4: begin
          send_word(OP_WRITE, OffCount, $urandom_range(1));
          ctrl[BitEnable] = 1'b1;
          send_word(OP_WRITE, OffControl, ctrl);
        end
        default: send_word(OP_TICK, 8'($urandom_range(255)), $urandom);
      endcase
      guard++;
    end
    // drop a countdown that outlived the guard
    if (wd_armed) begin
      ctrl = $urandom;
      ctrl[BitEnable] = 1'b0;
      ctrl[BitResetEnable] = 1'b0;
      send_word(OP_WRITE, OffControl, ctrl);
    end
  endtask

  task automatic test_random(int unsigned src_pct, int unsigned snk_pct);
    int unsigned phase_end;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    phase_end = words_sent + WordsPerPhase;
    while (words_sent < phase_end) begin
      if ($urandom_range(9) < 8) run_timeout_sequence();
      else repeat ($urandom_range(5, 1)) noise_word(1'b1);
    end
    drain_results();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.byte_offset = '0;
    in_if.write_data = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_register_map();
    test_countdown();
    drain_results();
    test_random(0, 0);
    test_random(46, 0);
    test_random(0, 46);
    test_random(13, 13);
    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
